FILE: hdl/tast_pkg.sv
// shared types and constants for the three axis step tracker
package tast_pkg;

  localparam int unsigned POS_WIDTH_DEF  = 32;
  localparam int unsigned KIND_WIDTH     = 2;
  localparam int unsigned AXIS_WIDTH     = 2;
  localparam int unsigned DELTA_WIDTH    = 2;
  localparam int unsigned NEW_POS_WIDTH  = 32;
  localparam int unsigned LEN_WIDTH      = 32;
  localparam int unsigned NUM_AXES       = 3;
  localparam int unsigned NUM_LEN_REGS   = 7;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 32;

  // command codes
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_STEP     = 2'd1,
    KIND_SET      = 2'd2,
    KIND_RESET    = 2'd3
  } cmd_kind_e;

  // axis codes
  localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

  // configuration register indexes, one per nonempty set of stepping axes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_X   = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_Y   = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_XY  = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_Z   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_XZ  = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_YZ  = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LEN_XYZ = 3'd6;

endpackage

FILE: hdl/tast_cmd_if.sv
// command channel interface: valid, ready and one command
interface tast_cmd_if;
  import tast_pkg::*;

  logic                            valid;
  logic                            ready;
  logic        [KIND_WIDTH-1:0]    kind;
  logic        [AXIS_WIDTH-1:0]    axis;
  logic signed [DELTA_WIDTH-1:0]   step_delta;
  logic signed [NEW_POS_WIDTH-1:0] new_x;
  logic signed [NEW_POS_WIDTH-1:0] new_y;
  logic signed [NEW_POS_WIDTH-1:0] new_z;

  modport source (
    output valid, kind, axis, step_delta, new_x, new_y, new_z,
    input  ready
  );

  modport sink (
    input  valid, kind, axis, step_delta, new_x, new_y, new_z,
    output ready
  );

endinterface

FILE: hdl/tast_res_if.sv
// result channel interface: valid, ready and one step report
interface tast_res_if;
  import tast_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 step_x;
  logic                 step_y;
  logic                 step_z;
  logic                 dir_x;
  logic                 dir_y;
  logic                 dir_z;
  logic                 ready_res;
  logic [LEN_WIDTH-1:0] step_length;

  modport source (
    output valid, step_x, step_y, step_z, dir_x, dir_y, dir_z, ready_res, step_length,
    input  ready
  );

  modport sink (
    input  valid, step_x, step_y, step_z, dir_x, dir_y, dir_z, ready_res, step_length,
    output ready
  );

endinterface

FILE: hdl/three_axis_step_tracker.sv
// three axis step tracker: position/target bookkeeping and step generation
//
//   channel  | dir | handshake     | contents
//   ---------+-----+---------------+---------------------------------------------
//   cmd_i    | in  | valid/ready   | kind, axis, step_delta, new_x/y/z
//   res_o    | out | valid/ready   | step_x/y/z, dir_x/y/z, ready_res, step_length
//   cfg      | in  | cfg_we_i only | cfg_idx_i selects len_x .. len_xyz
//
// one transaction per cycle sustained while results are taken; a command is
// registered in the input register and worked on there, and a step report is
// registered again in the output register before it is offered. the position
// adders and the difference compare per axis sit between the input register
// and the result register. rst_ni clears positions, targets and lengths. a
// stalled result holds in the output register; the work stage then holds only
// a step command behind it.
module three_axis_step_tracker #(
  parameter int unsigned POS_WIDTH = tast_pkg::POS_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tast_cmd_if.sink                           cmd_i,
  tast_res_if.source                         res_o,
  input  logic                               cfg_we_i,
  input  logic [tast_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [tast_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i
);

  import tast_pkg::*;

  // input register (work stage)
  logic                            s1_valid_q;
  cmd_kind_e                       s1_kind_q;
  logic        [AXIS_WIDTH-1:0]    s1_axis_q;
  logic signed [DELTA_WIDTH-1:0]   s1_delta_q;
  logic signed [NEW_POS_WIDTH-1:0] s1_new_q [NUM_AXES];

  // axis state
  logic [POS_WIDTH-1:0] cur_q [NUM_AXES];
  logic [POS_WIDTH-1:0] cur_d [NUM_AXES];
  logic [POS_WIDTH-1:0] tgt_q [NUM_AXES];
  logic [POS_WIDTH-1:0] tgt_d [NUM_AXES];

  // step lengths
  logic [LEN_WIDTH-1:0] len_q [NUM_LEN_REGS];

  // output register
  logic                 out_valid_q;
  logic [NUM_AXES-1:0]  out_step_q;
  logic [NUM_AXES-1:0]  out_dir_q;
  logic                 out_near_q;
  logic [LEN_WIDTH-1:0] out_len_q;

  // work stage results
  logic [NUM_AXES-1:0]  step_d;
  logic [NUM_AXES-1:0]  dir_d;
  logic                 near_d;
  logic [LEN_WIDTH-1:0] len_d;
  logic [POS_WIDTH:0]   diff [NUM_AXES];

  logic s1_is_step;
  logic s1_go;
  logic cmd_acc;
  logic res_load;

  // a step command needs room in the output register; others always leave
  assign s1_is_step = (s1_kind_q == KIND_STEP);
  assign s1_go      = s1_valid_q && (!s1_is_step || !out_valid_q || res_o.ready);
  assign res_load   = s1_go && s1_is_step;

  assign cmd_i.ready = !s1_valid_q || s1_go;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      s1_kind_q   <= cmd_kind_e'(cmd_i.kind);
      s1_axis_q   <= cmd_i.axis;
      s1_delta_q  <= cmd_i.step_delta;
      s1_new_q[0] <= cmd_i.new_x;
      s1_new_q[1] <= cmd_i.new_y;
      s1_new_q[2] <= cmd_i.new_z;
    end
  end

  // per axis difference, direction, step and next position
  always_comb begin
    near_d = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      // exact signed difference, one bit wider than a position
      diff[i]   = {tgt_q[i][POS_WIDTH-1], tgt_q[i]} - {cur_q[i][POS_WIDTH-1], cur_q[i]};
      dir_d[i]  = !diff[i][POS_WIDTH];
      step_d[i] = (diff[i] != '0);
      if (diff[i] != '0 && diff[i] != (POS_WIDTH+1)'(1) && diff[i] != '1) begin
        near_d = 1'b0;
      end
    end
  end

  // length for the set of stepping axes, zero when nothing steps
  always_comb begin
    if (step_d == '0) begin
      len_d = '0;
    end else begin
      len_d = len_q[step_d - NUM_AXES'(1)];
    end
  end

  // state update by command kind
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      cur_d[i] = cur_q[i];
      tgt_d[i] = tgt_q[i];
    end
    if (s1_go) begin
      case (s1_kind_q)
        KIND_SCHEDULE: begin
          // axis code 3 leaves every target alone
          for (int i = 0; i < NUM_AXES; i++) begin
            if (s1_axis_q == AXIS_WIDTH'(i)) begin
              tgt_d[i] = tgt_q[i] + POS_WIDTH'(s1_delta_q);
            end
          end
        end
        KIND_STEP: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (step_d[i]) begin
              cur_d[i] = dir_d[i] ? cur_q[i] + POS_WIDTH'(1) : cur_q[i] - POS_WIDTH'(1);
            end
          end
        end
        KIND_SET: begin
          // sign extend or keep the low bits of the loaded value
          for (int i = 0; i < NUM_AXES; i++) begin
            cur_d[i] = POS_WIDTH'(s1_new_q[i]);
            tgt_d[i] = POS_WIDTH'(s1_new_q[i]);
          end
        end
        KIND_RESET: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            cur_d[i] = '0;
            tgt_d[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_q[i] <= cur_d[i];
        tgt_q[i] <= tgt_d[i];
      end
    end
  end

  // configuration writes, indexes past the last length are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEN_REGS; i++) begin
        len_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEN_X:   len_q[0] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_Y:   len_q[1] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_XY:  len_q[2] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_Z:   len_q[3] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_XZ:  len_q[4] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_YZ:  len_q[5] <= LEN_WIDTH'(cfg_data_i);
        REG_LEN_XYZ: len_q[6] <= LEN_WIDTH'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_step_q <= step_d;
      out_dir_q  <= dir_d;
      out_near_q <= near_d;
      out_len_q  <= len_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.step_x      = out_step_q[0];
  assign res_o.step_y      = out_step_q[1];
  assign res_o.step_z      = out_step_q[2];
  assign res_o.dir_x       = out_dir_q[0];
  assign res_o.dir_y       = out_dir_q[1];
  assign res_o.dir_z       = out_dir_q[2];
  assign res_o.ready_res   = out_near_q;
  assign res_o.step_length = out_len_q;

endmodule

FILE: sim/three_axis_step_tracker_tb.sv
// testbench for the three axis step tracker: directed and random commands, self-checking
`timescale 1ns / 100ps

module three_axis_step_tracker_tb;
  import tast_pkg::*;

  localparam int unsigned POS_W = POS_WIDTH_DEF;
  // a step report passes the input register and the output register
  localparam int unsigned PIPE_DEPTH = 2;
  localparam int unsigned RANDOM_PER_PHASE = 355;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // axis code with no axis behind it, a schedule on it is dropped
  localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 2'd3;
  // register index past the last length register
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;

  // schedule deltas, the two-bit field read as signed
  localparam logic signed [DELTA_WIDTH-1:0] DELTA_ZERO      = 2'sb00;
  localparam logic signed [DELTA_WIDTH-1:0] DELTA_UP        = 2'sb01;
  localparam logic signed [DELTA_WIDTH-1:0] DELTA_MINUS_TWO = 2'sb10;
  localparam logic signed [DELTA_WIDTH-1:0] DELTA_DOWN      = 2'sb11;

  typedef enum {LENS_ZERO, LENS_ONES, LENS_RANDOM, LENS_PATTERN} len_fill_e;

  // one command as offered on the command channel
  typedef struct {
    cmd_kind_e                       kind;
    logic        [AXIS_WIDTH-1:0]    axis;
    logic signed [DELTA_WIDTH-1:0]   delta;
    logic signed [NEW_POS_WIDTH-1:0] new_x;
    logic signed [NEW_POS_WIDTH-1:0] new_y;
    logic signed [NEW_POS_WIDTH-1:0] new_z;
  } axis_cmd_t;

  // one step report; bit 0 is x, bit 1 y, bit 2 z
  typedef struct {
    logic [NUM_AXES-1:0]  stepped;
    logic [NUM_AXES-1:0]  fwd;
    logic                 near;
    logic [LEN_WIDTH-1:0] len;
  } step_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]  cfg_idx_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i;

  tast_cmd_if cmd ();
  tast_res_if res ();

  three_axis_step_tracker #(
    .POS_WIDTH(POS_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // tracker state as the testbench sees it
  logic [POS_W-1:0]     axis_pos[NUM_AXES];
  logic [POS_W-1:0]     axis_goal[NUM_AXES];
  // indexed by the set of stepping axes, entry 0 stays zero
  logic [LEN_WIDTH-1:0] len_by_axes[8];

  step_report_t pending_reports[$];
  int error_count = 0;

  // idle rates in percent, changed per phase
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  // cycles the result side still holds off, counted down by the sink process
  int hold_off_left = 0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
  endtask

  // advance the tracker state by one accepted command, queue a report for a step
  function automatic void track_cmd(input axis_cmd_t c);
    logic signed [POS_W:0] gap;
    step_report_t          r;
    case (c.kind)
      KIND_SCHEDULE: begin
        if (c.axis < NUM_AXES)
          axis_goal[c.axis] = axis_goal[c.axis] + {{(POS_W-DELTA_WIDTH){c.delta[1]}}, c.delta};
      end
      KIND_SET: begin
        axis_pos[0] = c.new_x[POS_W-1:0];
        axis_pos[1] = c.new_y[POS_W-1:0];
        axis_pos[2] = c.new_z[POS_W-1:0];
        for (int a = 0; a < NUM_AXES; a++) axis_goal[a] = axis_pos[a];
      end
      KIND_RESET: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          axis_pos[a] = '0;
          axis_goal[a] = '0;
        end
      end
      default: begin
        r.near = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
          // exact difference, one bit wider so far targets never look near
          gap = $signed({axis_goal[a][POS_W-1], axis_goal[a]})
              - $signed({axis_pos[a][POS_W-1], axis_pos[a]});
          r.stepped[a] = (gap != 0);
          r.fwd[a] = !gap[POS_W];
          if (gap > 1 || gap < -1) r.near = 1'b0;
          if (gap > 0) axis_pos[a] = axis_pos[a] + 1'b1;
          else if (gap < 0) axis_pos[a] = axis_pos[a] - 1'b1;
        end
        r.len = len_by_axes[r.stepped];
        pending_reports.push_back(r);
      end
    endcase
  endfunction

  function automatic axis_cmd_t make_cmd(input cmd_kind_e kind, input logic [AXIS_WIDTH-1:0] axis,
                                         input logic signed [DELTA_WIDTH-1:0] delta,
                                         input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
    axis_cmd_t c;
    c.kind = kind;
    c.axis = axis;
    c.delta = delta;
    c.new_x = x;
    c.new_y = y;
    c.new_z = z;
    return c;
  endfunction

  // positions near the wrap points and near zero are favored
  function automatic logic [31:0] random_position();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(7) - 4;
    endcase
  endfunction

  // mostly schedules and steps so targets stay near, now and then a set or reset
  function automatic axis_cmd_t random_cmd();
    axis_cmd_t c;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 40) c.kind = KIND_SCHEDULE;
    else if (pick < 85) c.kind = KIND_STEP;
    else if (pick < 95) c.kind = KIND_SET;
    else c.kind = KIND_RESET;
    // unused fields carry noise on purpose
    c.axis = ($urandom_range(19) == 0) ? AXIS_NONE : AXIS_WIDTH'($urandom_range(NUM_AXES - 1));
    c.delta = DELTA_WIDTH'($urandom_range(3));
    c.new_x = random_position();
    c.new_y = random_position();
    c.new_z = random_position();
    return c;
  endfunction

  // offer one command and wait for its transaction; valid stays high afterward
  task automatic send_cmd(input axis_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd.valid      <= 1'b1;
    cmd.kind       <= c.kind;
    cmd.axis       <= c.axis;
    cmd.step_delta <= c.delta;
    cmd.new_x      <= c.new_x;
    cmd.new_y      <= c.new_y;
    cmd.new_z      <= c.new_z;
    @(posedge clk_i);
    while (!cmd.ready) @(posedge clk_i);
    track_cmd(c);
  endtask

  // drop valid, let every report come back, then let the pipe run empty
  task automatic settle_block();
    @(negedge clk_i);
    cmd.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < NUM_LEN_REGS) len_by_axes[idx + 1] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // only called with the block idle
  task automatic load_lengths(input len_fill_e fill);
    logic [31:0] val;
    for (int i = 0; i < NUM_LEN_REGS; i++) begin
      case (fill)
        LENS_ZERO:    val = '0;
        LENS_ONES:    val = '1;
        LENS_PATTERN: val = {8'hA5, 8'h5A, 8'h00, 8'(i + 1)};
        default:      val = $urandom();
      endcase
      write_reg(CFG_IDX_WIDTH'(i), val);
    end
    // a write past the last register must not disturb any length
    write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_cmd(random_cmd());
  endtask

  // extremes and each special case by hand
  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // lengths still at reset: a step at rest reports nothing and length zero
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    settle_block();
    load_lengths(LENS_PATTERN);
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_X, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Y, DELTA_DOWN, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_Y, DELTA_ZERO, 0, 0, 0));
    // minus two on z: first step is not near, second one is
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Z, DELTA_MINUS_TWO, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_Z, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_Z, DELTA_ZERO, 0, 0, 0));
    // all three axes at once
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_X, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Y, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Z, DELTA_DOWN, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    // schedule on the missing axis is dropped
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_NONE, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    // targets wrap around the ends, the exact difference is then huge
    send_cmd(make_cmd(KIND_SET, AXIS_X, DELTA_ZERO, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_X, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Y, DELTA_DOWN, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_RESET, AXIS_X, DELTA_ZERO, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_X, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Y, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_SCHEDULE, AXIS_Z, DELTA_UP, 0, 0, 0));
    send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    settle_block();
  endtask

  // a short random burst under each length setting, extremes included
  task automatic test_length_settings();
    len_fill_e fills[4] = '{LENS_ZERO, LENS_ONES, LENS_RANDOM, LENS_PATTERN};
    src_idle_pct = 11;
    sink_stall_pct = 65;
    foreach (fills[f]) begin
      load_lengths(fills[f]);
      send_random(20);
      settle_block();
    end
  endtask

  task automatic test_random_stream(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    load_lengths(LENS_RANDOM);
    send_random(RANDOM_PER_PHASE);
    settle_block();
  endtask

  // the result side stops for a long stretch while commands keep coming,
  // so the pipe fills and the command side must stall
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    load_lengths(LENS_RANDOM);
    @(negedge clk_i);
    hold_off_left = HOLD_OFF_CYCLES;
    for (int n = 0; n < 40; n++) begin
      send_cmd(make_cmd(KIND_SCHEDULE, AXIS_WIDTH'($urandom_range(NUM_AXES - 1)),
                        DELTA_UP, 0, 0, 0));
      send_cmd(make_cmd(KIND_STEP, AXIS_X, DELTA_ZERO, 0, 0, 0));
    end
    settle_block();
  endtask

  // result side ready, with random stalls and the long hold-off
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        res.ready <= 1'b0;
        hold_off_left--;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // every report transaction against the oldest expectation
  always @(posedge clk_i) begin
    step_report_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_reports.size() == 0) begin
        report_error("step report with none expected");
      end else begin
        want = pending_reports.pop_front();
        check_field("step_x", res.step_x, want.stepped[0]);
        check_field("step_y", res.step_y, want.stepped[1]);
        check_field("step_z", res.step_z, want.stepped[2]);
        check_field("dir_x", res.dir_x, want.fwd[0]);
        check_field("dir_y", res.dir_y, want.fwd[1]);
        check_field("dir_z", res.dir_z, want.fwd[2]);
        check_field("ready_res", res.ready_res, want.near);
        check_field("step_length", res.step_length, want.len);
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("three_axis_step_tracker_tb failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cmd.valid = 1'b0;
    cmd.kind = KIND_SCHEDULE;
    cmd.axis = AXIS_X;
    cmd.step_delta = DELTA_ZERO;
    cmd.new_x = '0;
    cmd.new_y = '0;
    cmd.new_z = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_LEN_X;
    cfg_data_i = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      axis_pos[a] = '0;
      axis_goal[a] = '0;
    end
    foreach (len_by_axes[i]) len_by_axes[i] = '0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_length_settings();
    test_random_stream(11, 65);
    test_random_stream(65, 11);
    test_random_stream(0, 0);
    test_backpressure();

    if (error_count == 0) begin
      $display("three_axis_step_tracker_tb passed");
    end else begin
      $display("three_axis_step_tracker_tb failed");
    end
    $finish;
  end

endmodule
